>>> hdl/lakc_pkg.sv
package lakc_pkg;

  localparam int ENTRIES    = 8;
  localparam int KEY_BITS   = 64;
  localparam int AGE_BITS   = 32;
  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  typedef struct packed {
    logic        kind;
    logic [63:0] key;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  slot;
    logic        evicted;
    logic [62:0] evicted_key;
    logic        bad_key;
    logic        age_full;
  } result_t;

  // classified word handed from front to back
  typedef struct packed {
    logic                flush;
    logic                neg;
    logic [KEY_BITS-1:0] key;
  } cmd_t;

  function automatic logic [2:0] to_slot(input logic [IDX_BITS-1:0] idx);
    logic [IDX_BITS+2:0] w;
    w = {3'b000, idx};
    return w[2:0];
  endfunction

  // stored keys are never negative, so narrowing to 63 bits is exact
  function automatic logic [62:0] to_ekey(input logic [KEY_BITS-1:0] k);
    logic [63:0] w;
    w = '0;
    w[KEY_BITS-1:0] = k;
    return w[62:0];
  endfunction

endpackage

>>> hdl/lru_age_key_cache_unit.sv
// channel | ports                          | handshake
// input   | start, busy, item_i            | taken when start && !busy
// result  | result_valid_o, result_o       | one-cycle strobe, no back-pressure
//
// Lookup: from queue pop to result, a serial scan of the entry table, one
// entry per cycle, then the update state.
// Flush: the result is registered and appears in the cycle after the queue pop.
// A two-word queue sits between intake and the scan engine; busy is high
// while it is full. Reset clears all ages and the age counter at once.
module lru_age_key_cache_unit
  import lakc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output result_t result_o,
  output logic    result_valid_o
);

  logic push, full, q_valid, pop;
  cmd_t cmd_in, cmd_out;

  lakc_front u_front (
    .start_i (start),
    .item_i  (item_i),
    .full_i  (full),
    .push_o  (push),
    .cmd_o   (cmd_in)
  );

  lakc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  lakc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .cmd_i          (cmd_out),
    .pop_o          (pop),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  assign busy = full;

endmodule

>>> hdl/lakc_front.sv
module lakc_front
  import lakc_pkg::*;
(
  input  logic  start_i,
  input  item_t item_i,
  input  logic  full_i,
  output logic  push_o,
  output cmd_t  cmd_o
);

  assign push_o    = start_i && !full_i;
  assign cmd_o.flush = item_i.kind;
  assign cmd_o.key   = item_i.key[KEY_BITS-1:0];
  assign cmd_o.neg   = item_i.key[KEY_BITS-1];

endmodule

>>> hdl/lakc_queue.sv
module lakc_queue
  import lakc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                 mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_BITS-1:0] inc_ptr(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == QCNT_BITS'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? inc_ptr(wptr_q) : wptr_q;
    rptr_d = pop_i ? inc_ptr(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_BITS'(QDEPTH)) else $error("queue count out of range");

endmodule

>>> hdl/lakc_back.sv
module lakc_back
  import lakc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  cmd_t    cmd_i,
  output logic    pop_o,
  output result_t result_o,
  output logic    result_valid_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPD} state_e;

  state_e               st_q;
  cmd_t                 cmd_q;
  logic [IDX_BITS-1:0]  idx_q;
  logic                 found_q;
  logic [IDX_BITS-1:0]  fidx_q, midx_q;
  logic [AGE_BITS-1:0]  min_age_q;
  logic [KEY_BITS-1:0]  min_key_q;
  logic [AGE_BITS-1:0]  ctr_q;
  logic [AGE_BITS-1:0]  age_q [ENTRIES];
  logic [KEY_BITS-1:0]  key_q [ENTRIES];
  result_t              res_q;
  logic                 res_valid_q;

  logic [AGE_BITS-1:0]  age_rd, ctr_nxt;
  logic [KEY_BITS-1:0]  key_rd;
  logic                 match, take_min, last, alloc;

  assign pop_o   = (st_q == ST_IDLE) && valid_i;
  assign age_rd  = age_q[idx_q];
  assign key_rd  = key_q[idx_q];
  assign match   = (age_rd != '0) && (key_rd == cmd_q.key);
  assign take_min = (idx_q == '0) || (age_rd < min_age_q);
  assign last    = (idx_q == IDX_BITS'(ENTRIES - 1));
  assign ctr_nxt = (ctr_q == AGE_MAX) ? ctr_q : ctr_q + 1'b1;
  assign alloc   = (st_q == ST_UPD) && !found_q && !cmd_q.neg;

  always_ff @(posedge clk_i) begin
    if (alloc) begin
      key_q[midx_q] <= cmd_q.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cmd_q       <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      fidx_q      <= '0;
      midx_q      <= '0;
      min_age_q   <= '0;
      min_key_q   <= '0;
      ctr_q       <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      case (st_q)
        ST_IDLE: begin
          res_valid_q <= valid_i && cmd_i.flush;
          if (valid_i) begin
            if (cmd_i.flush) begin
              for (int i = 0; i < ENTRIES; i++) begin
                age_q[i] <= '0;
              end
              res_q <= '{hit: 1'b0, slot: 3'd0, evicted: 1'b0, evicted_key: '0,
                         bad_key: 1'b0, age_full: (ctr_q == AGE_MAX)};
            end else begin
              cmd_q   <= cmd_i;
              idx_q   <= '0;
              found_q <= 1'b0;
              st_q    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          res_valid_q <= 1'b0;
          if (match && !found_q) begin
            found_q <= 1'b1;
            fidx_q  <= idx_q;
          end
          if (take_min) begin
            min_age_q <= age_rd;
            min_key_q <= key_rd;
            midx_q    <= idx_q;
          end
          if (last) begin
            st_q <= ST_UPD;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_UPD: begin
          res_valid_q <= 1'b1;
          st_q        <= ST_IDLE;
          if (found_q) begin
            age_q[fidx_q] <= ctr_nxt;
            ctr_q         <= ctr_nxt;
            res_q <= '{hit: 1'b1, slot: to_slot(fidx_q), evicted: 1'b0,
                       evicted_key: '0, bad_key: 1'b0,
                       age_full: (ctr_nxt == AGE_MAX)};
          end else if (cmd_q.neg) begin
            res_q <= '{hit: 1'b0, slot: 3'd0, evicted: 1'b0, evicted_key: '0,
                       bad_key: 1'b1, age_full: (ctr_q == AGE_MAX)};
          end else begin
            age_q[midx_q] <= ctr_nxt;
            ctr_q         <= ctr_nxt;
            res_q <= '{hit: 1'b0, slot: to_slot(midx_q),
                       evicted: (min_age_q != '0),
                       evicted_key: (min_age_q != '0) ? to_ekey(min_key_q) : '0,
                       bad_key: 1'b0, age_full: (ctr_nxt == AGE_MAX)};
          end
        end
        default: begin
          res_valid_q <= 1'b0;
          st_q        <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

  a_bad_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.bad_key |-> !res_q.hit && !res_q.evicted)
    else $error("bad key word carries hit or eviction");
  a_age_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ctr_q >= $past(ctr_q)) else $error("age counter went backwards");
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(st_q == ST_UPD) || $past(pop_o && cmd_i.flush))
    else $error("result without a finished item");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lakc_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_WORDS = 550;
  localparam int POOL_SIZE = 12;

  class cache_shadow;
    logic [63:0] keys [ENTRIES];
    logic [AGE_BITS-1:0] ages [ENTRIES];
    logic [AGE_BITS-1:0] age_now;
    result_t pending_results[$];
    int mismatches;
    int n_words, n_hits, n_evicts, n_bad, n_flush;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        keys[i] = '0;
        ages[i] = '0;
      end
      age_now = '0;
    endfunction

    function logic [AGE_BITS-1:0] bump_age();
      if (age_now != AGE_MAX) age_now++;
      return age_now;
    endfunction

    function result_t predict_lookup(item_t it);
      result_t r;
      int found;
      int best;
      r = '0;
      found = -1;
      best = 0;
      if (it.kind) begin
        for (int i = 0; i < ENTRIES; i++) ages[i] = '0;
        n_flush++;
      end else begin
        for (int i = 0; i < ENTRIES; i++)
          if (found < 0 && ages[i] != 0 && keys[i] == it.key) found = i;
        if (found >= 0) begin
          ages[found] = bump_age();
          r.hit = 1'b1;
          r.slot = 3'(found);
          n_hits++;
        end else if (it.key[63]) begin
          r.bad_key = 1'b1;
          n_bad++;
        end else begin
          for (int i = 1; i < ENTRIES; i++)
            if (ages[i] < ages[best]) best = i;
          if (ages[best] != 0) begin
            r.evicted = 1'b1;
            r.evicted_key = keys[best][62:0];
            n_evicts++;
          end
          keys[best] = it.key;
          ages[best] = bump_age();
          r.slot = 3'(best);
        end
      end
      r.age_full = (age_now == AGE_MAX);
      return r;
    endfunction

    function void take_item(item_t it);
      n_words++;
      pending_results.push_back(predict_lookup(it));
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending", 64'(got), '0);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
        if (got.slot !== want.slot) report_mismatch("slot", 64'(got.slot), 64'(want.slot));
        if (got.evicted !== want.evicted)
          report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
        if (got.evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", 64'(got.evicted_key), 64'(want.evicted_key));
        if (got.bad_key !== want.bad_key)
          report_mismatch("bad_key", 64'(got.bad_key), 64'(want.bad_key));
        if (got.age_full !== want.age_full)
          report_mismatch("age_full", 64'(got.age_full), 64'(want.age_full));
      end
    endtask
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  result_t result_o;
  logic    result_valid_o;

  cache_shadow sb;
  int idle_cycles;
  logic [63:0] key_pool [POOL_SIZE];
  item_t directed[$];

  lru_age_key_cache_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .item_i(item_i),
    .result_o(result_o),
    .result_valid_o(result_valid_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic item_t lookup_word(logic [63:0] k);
    item_t it;
    it.kind = 1'b0;
    it.key = k;
    return it;
  endfunction

  function automatic item_t flush_word();
    item_t it;
    it.kind = 1'b1;
    it.key = {$urandom, $urandom};
    return it;
  endfunction

  function automatic logic [63:0] pool_key();
    logic [63:0] k;
    k = {1'b0, 31'($urandom), $urandom};
    // some small keys too
    if ($urandom_range(3) == 0) k = 64'($urandom_range(15));
    return k;
  endfunction

  task automatic send_word(item_t it, bit allow_gap);
    while (allow_gap && $urandom_range(99) < 32) begin
      start <= 1'b0;
      item_i <= item_t'({1'($urandom), $urandom, $urandom});
      @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(result_o);
      if (start && !busy) sb.take_item(item_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("lru_age_key_cache_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int r;
    item_t it;
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    idle_cycles = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = pool_key();

    directed.push_back(flush_word());
    directed.push_back(lookup_word(64'h0));
    directed.push_back(lookup_word(64'h0));
    directed.push_back(lookup_word(64'h7FFF_FFFF_FFFF_FFFF));
    directed.push_back(lookup_word(64'h8000_0000_0000_0000));
    directed.push_back(lookup_word(64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(lookup_word(64'h2AAA_AAAA_AAAA_AAAA));
    directed.push_back(lookup_word(64'h5555_5555_5555_5555));
    for (int k = 3; k <= 6; k++) directed.push_back(lookup_word(64'(k)));
    directed.push_back(lookup_word(64'd7));
    directed.push_back(lookup_word(64'h7FFF_FFFF_FFFF_FFFF));
    directed.push_back(lookup_word(64'd8));
    directed.push_back(lookup_word(64'h5555_5555_5555_5555));
    directed.push_back(flush_word());
    directed.push_back(lookup_word(64'd7));
    directed.push_back(lookup_word(64'd7));
    directed.push_back(lookup_word({1'b1, 31'($urandom), $urandom}));
    directed.push_back(lookup_word(64'h0));
    directed.push_back(flush_word());

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_word(directed[i], 1'b1);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      r = $urandom_range(99);
      if ($urandom_range(99) < 2) key_pool[$urandom_range(POOL_SIZE - 1)] = pool_key();
      if (r < 3) it = flush_word();
      else if (r < 10) it = lookup_word({$urandom, $urandom});
      else if (r < 15) it = lookup_word({1'b1, 31'($urandom), $urandom});
      else it = lookup_word(key_pool[$urandom_range(POOL_SIZE - 1)]);
      if (n == 100) begin
        // drain before carrying on
        start <= 1'b0;
        @(posedge clk_i);
        while (sb.pending_results.size() != 0) @(posedge clk_i);
      end
      send_word(it, !(n >= 200 && n < 330));
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4 * (ENTRIES + 2)) @(posedge clk_i);

    $display("%0d words: %0d hits, %0d evictions, %0d negative-key misses, %0d flushes",
             sb.n_words, sb.n_hits, sb.n_evicts, sb.n_bad, sb.n_flush);
    $display("%0d field mismatches, %0d results outstanding",
             sb.mismatches, sb.pending_results.size());
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("lru_age_key_cache_unit test passed");
    end else begin
      $display("lru_age_key_cache_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/lakc_pkg.sv
hdl/lakc_front.sv
hdl/lakc_queue.sv
hdl/lakc_back.sv
hdl/lru_age_key_cache_unit.sv
sim/tb_top.sv
